>>> rtl/ichi_pkg.sv
// ----------------------------------------------------------------------------
// ichi_pkg
// Shared types, widths and default settings for the ichimoku indicator block.
// ----------------------------------------------------------------------------
package ichi_pkg;

   // price word width and its sum width for midpoint forming
   localparam int PRICE_W = 24;
   localparam int SUM_W   = PRICE_W + 1;

   // default window settings
   localparam int HISTORY_DEPTH_DEF = 128;
   localparam int TENKAN_LEN_DEF    = 9;
   localparam int KIJUN_LEN_DEF     = 26;
   localparam int SPAN_B_LEN_DEF    = 52;
   localparam int DISPLACEMENT_DEF  = 25;

   typedef logic [PRICE_W-1:0] price_type;

   // position codes
   typedef enum logic [1:0] {
      POS_FLAT  = 2'd0,
      POS_LONG  = 2'd1,
      POS_SHORT = 2'd2
   } pos_type;

   // entry signal codes
   typedef enum logic [1:0] {
      SIG_NONE = 2'd0,
      SIG_BUY  = 2'd1,
      SIG_SELL = 2'd2
   } sig_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEAR,
      ST_FAR,
      ST_CALC,
      ST_FINISH
   } state_type;

   // gated indicator values for the decision logic
   typedef struct packed {
      price_type close;
      price_type tenkan;
      price_type kijun;
      price_type span_a;
      price_type span_b;
      price_type past;
      logic      all_ok;
   } ind_type;

   // decision result
   typedef struct packed {
      sig_type sig;
      pos_type pos;
   } dec_type;

endpackage

>>> rtl/ichi_hist_ram.sv
// ----------------------------------------------------------------------------
// ichi_hist_ram
// Close price history: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ichi_hist_ram #(
   parameter int DEPTH = ichi_pkg::HISTORY_DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ichi_pkg::price_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ichi_pkg::price_type rd_data
);

   ichi_pkg::price_type mem [DEPTH];
   ichi_pkg::price_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ichi_range_unit.sv
// ----------------------------------------------------------------------------
// ichi_range_unit
// Running max/min over a stream of words, with the floored midpoint.
// ----------------------------------------------------------------------------
module ichi_range_unit (
   input  logic                clock,
   input  logic                load,
   input  logic                first,
   input  ichi_pkg::price_type value,
   output ichi_pkg::price_type mid
);

   ichi_pkg::price_type hi_ff, hi_in;
   ichi_pkg::price_type lo_ff, lo_in;
   logic [ichi_pkg::SUM_W-1:0] sum;

   // compare and select, first word of a window seeds both bounds
   always_comb begin
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (load) begin
         if (first || (value > hi_ff)) hi_in = value;
         if (first || (value < lo_ff)) lo_in = value;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   // midpoint, halving rounds down
   assign sum = {1'b0, hi_ff} + {1'b0, lo_ff};
   assign mid = sum[ichi_pkg::SUM_W-1:1];

endmodule

>>> rtl/ichi_signal_logic.sv
// ----------------------------------------------------------------------------
// ichi_signal_logic
// Entry and exit decisions from the five trend conditions.
// ----------------------------------------------------------------------------
module ichi_signal_logic (
   input  ichi_pkg::ind_type ind,
   input  ichi_pkg::pos_type pos,
   output ichi_pkg::dec_type dec
);

   logic buy_all;
   logic sell_all;
   logic long_fail;
   logic short_fail;

   // all five conditions, strict
   assign buy_all  = (ind.close > ind.tenkan) && (ind.tenkan > ind.kijun) &&
                     (ind.close > ind.span_a) && (ind.span_a > ind.span_b) &&
                     (ind.close > ind.past);
   assign sell_all = (ind.close < ind.tenkan) && (ind.tenkan < ind.kijun) &&
                     (ind.close < ind.span_a) && (ind.span_a < ind.span_b) &&
                     (ind.close < ind.past);

   // an open position closes only when a condition is strictly reversed
   assign long_fail  = (ind.close < ind.tenkan) || (ind.tenkan < ind.kijun) ||
                       (ind.close < ind.span_a) || (ind.span_a < ind.span_b) ||
                       (ind.close < ind.past);
   assign short_fail = (ind.close > ind.tenkan) || (ind.tenkan > ind.kijun) ||
                       (ind.close > ind.span_a) || (ind.span_a > ind.span_b) ||
                       (ind.close > ind.past);

   // position decoder
   always_comb begin
      dec.sig = ichi_pkg::SIG_NONE;
      dec.pos = pos;
      unique case (pos)
         ichi_pkg::POS_LONG: begin
            if (long_fail) dec.pos = ichi_pkg::POS_FLAT;
         end
         ichi_pkg::POS_SHORT: begin
            if (short_fail) dec.pos = ichi_pkg::POS_FLAT;
         end
         default: begin
            dec.pos = ichi_pkg::POS_FLAT;
            if (ind.all_ok && buy_all) begin
               dec.sig = ichi_pkg::SIG_BUY;
               dec.pos = ichi_pkg::POS_LONG;
            end else if (ind.all_ok && sell_all) begin
               dec.sig = ichi_pkg::SIG_SELL;
               dec.pos = ichi_pkg::POS_SHORT;
            end
         end
      endcase
   end

endmodule

>>> rtl/ichimoku_indicator_signal.sv
// ----------------------------------------------------------------------------
// ichimoku_indicator_signal
// Ichimoku trend indicator with entry/exit signals, one close price per bar.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one close price word per bar. req_stall is high
//   while a bar is being worked on; a word is taken when req_valid is high
//   and req_stall is low.
//   rsp_ channel returns one result word per bar: tenkan and kijun
//   midpoints, span A, span B, entry signal and position. The result sits in
//   an output register and holds while rsp_stall is high; the next bar can
//   be taken and worked on meanwhile, and only its final load waits.
//   Each bar is worked on by one shared max/min unit walking the
//   history memory one word a cycle through its single read port: one pass
//   over the current windows, one over the displaced windows.
//   Reset: bar count, write pointer and position clear; the history memory
//   is not cleared, warm-up gating keeps unwritten words from being used.
// ----------------------------------------------------------------------------
module ichimoku_indicator_signal #(
   parameter int HISTORY_DEPTH = ichi_pkg::HISTORY_DEPTH_DEF,
   parameter int TENKAN_LEN    = ichi_pkg::TENKAN_LEN_DEF,
   parameter int KIJUN_LEN     = ichi_pkg::KIJUN_LEN_DEF,
   parameter int SPAN_B_LEN    = ichi_pkg::SPAN_B_LEN_DEF,
   parameter int DISPLACEMENT  = ichi_pkg::DISPLACEMENT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ichi_pkg::PRICE_W-1:0] req_close_price,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ichi_pkg::PRICE_W-1:0] rsp_tenkan_mid,
   output logic [ichi_pkg::PRICE_W-1:0] rsp_kijun_mid,
   output logic [ichi_pkg::PRICE_W-1:0] rsp_span_a,
   output logic [ichi_pkg::PRICE_W-1:0] rsp_span_b,
   output logic [1:0]                   rsp_entry_signal,
   output logic [1:0]                   rsp_position_now
);

   // derived sizes
   localparam int AW        = $clog2(HISTORY_DEPTH);
   localparam int TK_MAX    = (TENKAN_LEN > KIJUN_LEN) ? TENKAN_LEN : KIJUN_LEN;
   localparam int FAR_LEN   = (TK_MAX > SPAN_B_LEN) ? TK_MAX : SPAN_B_LEN;
   localparam int SA_WARM   = DISPLACEMENT + TK_MAX;
   localparam int SB_WARM   = DISPLACEMENT + SPAN_B_LEN;
   localparam int BK_WARM   = DISPLACEMENT + 1;
   localparam int SAT_AB    = (SA_WARM > SB_WARM) ? SA_WARM : SB_WARM;
   localparam int BARS_SAT  = (SAT_AB > BK_WARM) ? SAT_AB : BK_WARM;
   localparam int BW        = $clog2(BARS_SAT + 1);
   localparam int CW        = $clog2(FAR_LEN + 2);

   localparam logic [CW-1:0] NEAR_LAST = CW'(TK_MAX + 1);
   localparam logic [CW-1:0] FAR_LAST  = CW'(FAR_LEN + 1);
   localparam logic [CW-1:0] NEAR_RD   = CW'(TK_MAX);
   localparam logic [CW-1:0] FAR_RD    = CW'(FAR_LEN);
   localparam logic [CW-1:0] TK_IDX    = CW'(TENKAN_LEN - 1);
   localparam logic [CW-1:0] KJ_IDX    = CW'(KIJUN_LEN - 1);
   localparam logic [CW-1:0] SB_IDX    = CW'(SPAN_B_LEN - 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);
   localparam logic [AW:0]   DISP_EXT  = (AW+1)'(DISPLACEMENT);
   localparam logic [AW-1:0] PTR_LAST  = AW'(HISTORY_DEPTH - 1);
   localparam logic [BW-1:0] BARS_TOP  = BW'(BARS_SAT);

   ichi_pkg::state_type state_ff, state_in;

   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [BW-1:0]       bars_ff, bars_in;
   ichi_pkg::pos_type   pos_ff, pos_in;
   ichi_pkg::price_type close_ff;

   // read pipeline tags
   logic          vld_d1_ff, vld_d2_ff;
   logic [CW-1:0] idx_d1_ff, idx_d2_ff;

   // window snapshots
   ichi_pkg::price_type tk_near_ff, kj_near_ff, tk_far_ff, kj_far_ff;
   ichi_pkg::price_type sb_far_ff, past_ff, span_a_ff;

   // output word
   logic                rsp_valid_ff;
   ichi_pkg::price_type rsp_tk_ff, rsp_kj_ff, rsp_sa_ff, rsp_sb_ff;
   ichi_pkg::sig_type   rsp_sig_ff;
   ichi_pkg::pos_type   rsp_pos_ff;

   // sequencer outputs
   logic accept;
   logic in_pass;
   logic pass_done;
   logic rd_issue;
   logic out_free;
   logic load_out;

   logic [AW:0]         k_ext;
   logic [AW:0]         wr_ext;
   logic [AW-1:0]       rd_addr;
   logic [ichi_pkg::SUM_W-1:0] sa_sum;
   ichi_pkg::price_type rd_data;
   ichi_pkg::price_type mid;
   ichi_pkg::ind_type   ind;
   ichi_pkg::dec_type   dec;

   logic ts_ok, ks_ok, sa_ok, sb_ok, bk_ok;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ichi_pkg::ST_IDLE:   if (req_valid) state_in = ichi_pkg::ST_NEAR;
         ichi_pkg::ST_NEAR:   if (pass_done) state_in = ichi_pkg::ST_FAR;
         ichi_pkg::ST_FAR:    if (pass_done) state_in = ichi_pkg::ST_CALC;
         ichi_pkg::ST_CALC:   state_in = ichi_pkg::ST_FINISH;
         ichi_pkg::ST_FINISH: if (out_free) state_in = ichi_pkg::ST_IDLE;
         default:             state_in = ichi_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      in_pass   = 1'b0;
      pass_done = 1'b0;
      rd_issue  = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ichi_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         ichi_pkg::ST_NEAR: begin
            in_pass   = 1'b1;
            pass_done = (cnt_ff == NEAR_LAST);
            rd_issue  = (cnt_ff < NEAR_RD);
         end
         ichi_pkg::ST_FAR: begin
            in_pass   = 1'b1;
            pass_done = (cnt_ff == FAR_LAST);
            rd_issue  = (cnt_ff < FAR_RD);
         end
         ichi_pkg::ST_FINISH: begin
            load_out = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // walk counter
   assign cnt_in = (in_pass && !pass_done) ? cnt_ff + 1'b1 : '0;

   // address of the close k bars back, one wrap at most
   assign k_ext   = (state_ff == ichi_pkg::ST_FAR) ? DISP_EXT + (AW+1)'(cnt_ff)
                                                   : (AW+1)'(cnt_ff);
   assign wr_ext  = {1'b0, wr_ptr_ff};
   assign rd_addr = (wr_ext >= k_ext) ? AW'(wr_ext - k_ext)
                                      : AW'(wr_ext + DEPTH_EXT - k_ext);

   ichi_hist_ram #(
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_close_price),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ichi_range_unit u_range (
      .clock (clock),
      .load  (vld_d1_ff),
      .first (idx_d1_ff == '0),
      .value (rd_data),
      .mid   (mid)
   );

   // bar count, pointer and position
   assign bars_in   = (accept && (bars_ff < BARS_TOP)) ? bars_ff + 1'b1 : bars_ff;
   assign wr_ptr_in = !load_out ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign pos_in    = load_out ? dec.pos : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ichi_pkg::ST_IDLE;
         cnt_ff       <= '0;
         wr_ptr_ff    <= '0;
         bars_ff      <= '0;
         pos_ff       <= ichi_pkg::POS_FLAT;
         vld_d1_ff    <= 1'b0;
         vld_d2_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         bars_ff   <= bars_in;
         pos_ff    <= pos_in;
         vld_d1_ff <= rd_issue;
         vld_d2_ff <= vld_d1_ff;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pipeline tags and snapshots of the running midpoint
   always_ff @(posedge clock) begin
      idx_d1_ff <= cnt_ff;
      idx_d2_ff <= idx_d1_ff;
      if (accept) close_ff <= req_close_price;
      if (vld_d2_ff && (state_ff == ichi_pkg::ST_NEAR)) begin
         if (idx_d2_ff == TK_IDX) tk_near_ff <= mid;
         if (idx_d2_ff == KJ_IDX) kj_near_ff <= mid;
      end
      if (vld_d2_ff && (state_ff == ichi_pkg::ST_FAR)) begin
         if (idx_d2_ff == '0)     past_ff    <= mid;
         if (idx_d2_ff == TK_IDX) tk_far_ff  <= mid;
         if (idx_d2_ff == KJ_IDX) kj_far_ff  <= mid;
         if (idx_d2_ff == SB_IDX) sb_far_ff  <= mid;
      end
      if (state_ff == ichi_pkg::ST_CALC) span_a_ff <= sa_sum[ichi_pkg::SUM_W-1:1];
   end

   assign sa_sum = {1'b0, tk_far_ff} + {1'b0, kj_far_ff};

   // warm-up gating
   assign ts_ok = (bars_ff >= BW'(TENKAN_LEN));
   assign ks_ok = (bars_ff >= BW'(KIJUN_LEN));
   assign sa_ok = (bars_ff >= BW'(SA_WARM));
   assign sb_ok = (bars_ff >= BW'(SB_WARM));
   assign bk_ok = (bars_ff >= BW'(BK_WARM));

   always_comb begin
      ind.close  = close_ff;
      ind.tenkan = ts_ok ? tk_near_ff : '0;
      ind.kijun  = ks_ok ? kj_near_ff : '0;
      ind.span_a = sa_ok ? span_a_ff : '0;
      ind.span_b = sb_ok ? sb_far_ff : '0;
      ind.past   = bk_ok ? past_ff : '0;
      ind.all_ok = ts_ok && ks_ok && sa_ok && sb_ok && bk_ok;
   end

   ichi_signal_logic u_signal (
      .ind (ind),
      .pos (pos_ff),
      .dec (dec)
   );

   // output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tk_ff  <= ind.tenkan;
         rsp_kj_ff  <= ind.kijun;
         rsp_sa_ff  <= ind.span_a;
         rsp_sb_ff  <= ind.span_b;
         rsp_sig_ff <= dec.sig;
         rsp_pos_ff <= dec.pos;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tenkan_mid   = rsp_tk_ff;
   assign rsp_kijun_mid    = rsp_kj_ff;
   assign rsp_span_a       = rsp_sa_ff;
   assign rsp_span_b       = rsp_sb_ff;
   assign rsp_entry_signal = rsp_sig_ff;
   assign rsp_position_now = rsp_pos_ff;

endmodule
